/* design/rht_pkg.sv */
// Package with opcode, status and state codes for the rectangle hit-test table.
package rht_pkg;
    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_HIT    = 3'd2;
    localparam logic [2:0] OP_FIND   = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;
    localparam logic [2:0] S_MUL   = 3'd5;
endpackage

/* design/rectangle_hit_test_table.sv */
// Ordered table of tagged rectangles with append, remove, find, read, clear and point hit test.
//
// One request enters on the input channel (i_valid/o_ready) and exactly one result
// leaves on the output channel (o_valid/i_ready). One request is in work at a time.
// Entries live in one synchronous memory read one address per cycle with a registered
// read port; the sequencer takes each entry it fetches through three states
// (issue the read, wait for the data, check it).
// Append, clear, unused opcodes, out-of-range positions, and find or hit test on an
// empty table visit no entries; read visits one. Find stops at the first entry whose
// tag matches, or after the last entry. Hit test visits every entry and spends one
// more step on each box that contains the point. Remove reads the removed entry,
// then moves each later entry down one place.
// The result is held in an output register until taken; while the receiver
// stalls no new request is accepted, and the next request is accepted from the
// cycle after the result is taken. Reset empties the table at once (the fill
// count is cleared, entry contents stay undefined) and drops any result.
module rectangle_hit_test_table #(
    parameter int MAX_ENTRIES = 64,
    parameter int COORD_BITS  = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [2:0]                   i_opcode,
    input  logic [5:0]                   i_position,
    input  logic [31:0]                  i_tag,
    input  logic signed [COORD_BITS-1:0] i_left,
    input  logic signed [COORD_BITS-1:0] i_top,
    input  logic signed [COORD_BITS-1:0] i_right,
    input  logic signed [COORD_BITS-1:0] i_bottom,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [1:0]                   o_status,
    output logic [5:0]                   o_hit_position,
    output logic [31:0]                  o_hit_tag,
    output logic signed [COORD_BITS-1:0] o_hit_left,
    output logic signed [COORD_BITS-1:0] o_hit_top,
    output logic signed [COORD_BITS-1:0] o_hit_right,
    output logic signed [COORD_BITS-1:0] o_hit_bottom,
    output logic [6:0]                   o_entry_total
);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int DW = COORD_BITS + 1;
    localparam int EW = 32 + 4 * COORD_BITS;

    typedef logic [EW-1:0] t_entry;

    t_entry r_mem [MAX_ENTRIES];
    t_entry r_rdata;
    logic   r_we;
    logic [AW-1:0] r_waddr;
    t_entry r_wdata;
    logic [AW-1:0] n_raddr;
    logic   n_re;

    always_ff @(posedge i_clk) begin
        if (r_we) r_mem[r_waddr] <= r_wdata;
        if (n_re) r_rdata <= r_mem[n_raddr];
    end

    logic [2:0]  r_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [2:0]  r_op;
    logic [31:0] r_tag;
    logic signed [COORD_BITS-1:0] r_px, r_py;
    logic        r_have;
    logic [AW-1:0] r_best;
    t_entry      r_best_e;
    logic [DW-1:0] r_bw, r_bh, r_cw, r_ch;
    logic [2*DW-1:0] r_barea, r_carea;
    t_entry      r_cur;
    logic        r_valid;
    logic [1:0]  r_status;
    logic [5:0]  r_hpos;
    t_entry      r_hent;

    logic signed [COORD_BITS-1:0] e_l, e_t, e_r, e_b;
    logic [31:0] e_tag;
    assign e_tag = r_rdata[EW-1 -: 32];
    assign e_l = r_rdata[4*COORD_BITS-1 -: COORD_BITS];
    assign e_t = r_rdata[3*COORD_BITS-1 -: COORD_BITS];
    assign e_r = r_rdata[2*COORD_BITS-1 -: COORD_BITS];
    assign e_b = r_rdata[COORD_BITS-1:0];

    logic contained;
    assign contained = (r_px >= e_l) && (r_py >= e_t) && (r_px <= e_r) && (r_py <= e_b);
    logic [DW-1:0] w_now, h_now;
    assign w_now = DW'($signed({e_r[COORD_BITS-1], e_r}) - $signed({e_l[COORD_BITS-1], e_l}));
    assign h_now = DW'($signed({e_b[COORD_BITS-1], e_b}) - $signed({e_t[COORD_BITS-1], e_t}));

    logic smaller;
    always_comb begin
        if (r_cw == r_bw)      smaller = r_ch < r_bh;
        else if (r_ch == r_bh) smaller = r_cw < r_bw;
        else                   smaller = r_carea < r_barea;
    end

    logic take_out;
    assign take_out = r_valid && i_ready;
    assign o_ready  = (r_state == rht_pkg::S_IDLE) && !r_valid;
    logic acc;
    assign acc = i_valid && o_ready;

    always_comb begin
        n_re = 1'b0;
        n_raddr = '0;
        if (acc) begin
            n_re = 1'b1;
            n_raddr = (i_opcode == rht_pkg::OP_HIT || i_opcode == rht_pkg::OP_FIND)
                      ? '0 : AW'(i_position);
        end else if (r_state == rht_pkg::S_FETCH) begin
            n_re = 1'b1;
            n_raddr = r_idx[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rht_pkg::S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_we    <= 1'b0;
        end else begin
            r_we <= 1'b0;
            if (take_out) r_valid <= 1'b0;
            case (r_state)
                rht_pkg::S_IDLE: begin
                    if (acc) begin
                        r_op <= i_opcode;
                        r_tag <= i_tag;
                        r_px <= i_point_x;
                        r_py <= i_point_y;
                        r_have <= 1'b0;
                        r_hpos <= '0;
                        r_hent <= '0;
                        r_status <= rht_pkg::ST_OK;
                        r_idx <= '0;
                        case (i_opcode)
                            rht_pkg::OP_APPEND: begin
                                if (r_count >= CW'(MAX_ENTRIES)) begin
                                    r_status <= rht_pkg::ST_FULL;
                                end else begin
                                    r_we <= 1'b1;
                                    r_waddr <= r_count[AW-1:0];
                                    r_wdata <= {i_tag, i_left, i_top, i_right, i_bottom};
                                    r_hpos <= 6'(r_count);
                                    r_hent <= {i_tag, i_left, i_top, i_right, i_bottom};
                                    r_count <= r_count + 1'b1;
                                end
                                r_state <= rht_pkg::S_OUT;
                            end
                            rht_pkg::OP_REMOVE, rht_pkg::OP_READ: begin
                                if (CW'(i_position) >= r_count) begin
                                    r_status <= rht_pkg::ST_RANGE;
                                    r_state <= rht_pkg::S_OUT;
                                end else begin
                                    r_idx <= CW'(i_position) + 1'b1;
                                    r_best <= AW'(i_position);
                                    r_state <= rht_pkg::S_CHECK;
                                end
                            end
                            rht_pkg::OP_HIT, rht_pkg::OP_FIND: begin
                                r_status <= rht_pkg::ST_NONE;
                                if (r_count == '0) r_state <= rht_pkg::S_OUT;
                                else begin
                                    r_idx <= CW'(1);
                                    r_best <= '0;
                                    r_state <= rht_pkg::S_CHECK;
                                end
                            end
                            rht_pkg::OP_CLEAR: begin
                                r_count <= '0;
                                r_state <= rht_pkg::S_OUT;
                            end
                            default: r_state <= rht_pkg::S_OUT;
                        endcase
                    end
                end
                // Data of entry r_idx-1 (r_best: read position or remove's write slot).
                rht_pkg::S_CHECK: begin
                    case (r_op)
                        rht_pkg::OP_READ: begin
                            r_hpos <= 6'(r_best);
                            r_hent <= r_rdata;
                            r_state <= rht_pkg::S_OUT;
                        end
                        rht_pkg::OP_REMOVE: begin
                            if (!r_have) begin
                                r_have <= 1'b1;
                                r_hpos <= 6'(r_best);
                                r_hent <= r_rdata;
                            end else begin
                                r_we <= 1'b1;
                                r_waddr <= r_best;
                                r_wdata <= r_rdata;
                                r_best <= r_best + 1'b1;
                            end
                            if (r_idx >= r_count) begin
                                r_count <= r_count - 1'b1;
                                r_state <= rht_pkg::S_OUT;
                            end else begin
                                r_state <= rht_pkg::S_FETCH;
                            end
                        end
                        rht_pkg::OP_FIND: begin
                            if (e_tag == r_tag) begin
                                r_status <= rht_pkg::ST_OK;
                                r_hpos <= 6'(r_idx - 1'b1);
                                r_hent <= r_rdata;
                                r_state <= rht_pkg::S_OUT;
                            end else if (r_idx >= r_count) begin
                                r_state <= rht_pkg::S_OUT;
                            end else begin
                                r_state <= rht_pkg::S_FETCH;
                            end
                        end
                        default: begin
                            if (contained) begin
                                r_cw <= w_now;
                                r_ch <= h_now;
                                r_cur <= r_rdata;
                                r_carea <= w_now * h_now;
                                r_state <= rht_pkg::S_MUL;
                            end else if (r_idx >= r_count) begin
                                r_state <= rht_pkg::S_OUT;
                            end else begin
                                r_state <= rht_pkg::S_FETCH;
                            end
                        end
                    endcase
                end
                rht_pkg::S_MUL: begin
                    if (!r_have || smaller) begin
                        r_have <= 1'b1;
                        r_status <= rht_pkg::ST_OK;
                        r_bw <= r_cw;
                        r_bh <= r_ch;
                        r_barea <= r_carea;
                        r_hpos <= 6'(r_idx - 1'b1);
                        r_hent <= r_cur;
                    end
                    if (r_idx >= r_count) r_state <= rht_pkg::S_OUT;
                    else r_state <= rht_pkg::S_FETCH;
                end
                // Memory read of r_idx is issued this cycle.
                rht_pkg::S_FETCH: begin
                    r_idx <= r_idx + 1'b1;
                    r_state <= rht_pkg::S_SCAN;
                end
                rht_pkg::S_SCAN: r_state <= rht_pkg::S_CHECK;
                rht_pkg::S_OUT: begin
                    r_valid <= 1'b1;
                    r_state <= rht_pkg::S_IDLE;
                end
                default: r_state <= rht_pkg::S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_hit_position = r_hpos;
    assign o_hit_tag      = r_hent[EW-1 -: 32];
    assign o_hit_left     = r_hent[4*COORD_BITS-1 -: COORD_BITS];
    assign o_hit_top      = r_hent[3*COORD_BITS-1 -: COORD_BITS];
    assign o_hit_right    = r_hent[2*COORD_BITS-1 -: COORD_BITS];
    assign o_hit_bottom   = r_hent[COORD_BITS-1:0];
    assign o_entry_total  = 7'(r_count);
endmodule
